// File: rtl/core/fvlc_pkg.sv
package fvlc_pkg;

    localparam logic [15:0] SECTOR_BYTES = 16'd512;
    localparam int          SECTOR_SHIFT = 9;
    localparam int          ROOT_ALIGN_BITS = 6;   // 64-entry alignment
    localparam int          ENTRY_SHIFT = 4;       // 32-byte entries, 16 to a sector

    localparam logic [27:0] FAT16_END = 28'h000FFFF;
    localparam logic [27:0] FAT32_END = 28'hFFFFFFF;

    localparam int DIV_BITS      = 32;
    localparam int BITS_PER_STEP = 4;
    localparam int DIV_STAGES    = DIV_BITS / BITS_PER_STEP;
    localparam int PIPE_DEPTH    = DIV_STAGES + 3;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_SECTOR_SIZE = 4'd1,
        ST_ZERO_SPC    = 4'd2,
        ST_PARTITION   = 4'd3,
        ST_ZERO_FATS   = 4'd4,
        ST_ZERO_FSIZE  = 4'd5,
        ST_ROOT_COUNT  = 4'd6,
        ST_BELOW_TABLE = 4'd7,
        ST_BELOW_ROOT  = 4'd8,
        ST_BELOW_DATA  = 4'd9,
        ST_NO_CLUSTERS = 4'd10
    } status_t;

    // after the field checks and the FAT area product
    typedef struct packed {
        status_t     status;
        logic        is32;
        logic [31:0] total;
        logic [39:0] fat_area;
        logic [15:0] table_start;
        logic [11:0] root_sectors;
        logic [7:0]  spc;
    } chk_t;

    // travels down the divider
    typedef struct packed {
        status_t     status;
        logic        is32;
        logic [15:0] table_start;
        logic [31:0] root_start;
        logic [31:0] data_start;
        logic [31:0] total;
        logic [7:0]  spc;
        logic [31:0] dividend;
        logic [7:0]  partial;
        logic [31:0] quot;
    } div_t;

endpackage

// File: rtl/core/fat_volume_layout_check_core.sv
// Channel   Handshake                       Payload
// item      item_valid / item_ready         fat_kind .. partition_sectors
// result    result_valid / result_ready     status .. link_end
//
// One beat per cycle in and out unless a low result_ready stalls; each beat is registered in
// the check, layout, 8 divider stages of 4 restoring steps each, then the output stage.
// Reset clears only the stage valid bits; data registers hold whatever they last took.
// Each stage takes a new beat whenever it is empty or the stage after it moves,
// so bubbles close up behind a stalled result and nothing is dropped or repeated.
module fat_volume_layout_check_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic        fat_kind,
    input  logic [15:0] bytes_per_sector,
    input  logic [7:0]  sectors_per_cluster,
    input  logic [15:0] reserved_sectors,
    input  logic [7:0]  fat_copies,
    input  logic [15:0] root_entries,
    input  logic [15:0] total_small,
    input  logic [31:0] total_large,
    input  logic [15:0] fat_size_small,
    input  logic [31:0] fat_size_large,
    input  logic [31:0] partition_sectors,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [3:0]  status,
    output logic [31:0] table_start,
    output logic [31:0] root_start,
    output logic [31:0] data_start,
    output logic [31:0] data_clusters,
    output logic [16:0] cluster_bytes,
    output logic [31:0] total_sectors,
    output logic [27:0] link_end
);
    import fvlc_pkg::*;

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic [PIPE_DEPTH:0]   ready;

    chk_t    chk;
    div_t    div [0:DIV_STAGES];
    div_t    last;
    status_t final_status;
    logic    fail;

    always_comb
    begin
        ready[PIPE_DEPTH] = result_ready;
        for (int i = PIPE_DEPTH - 1; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
        valid_next[0] = ready[0] ? item_valid : valid_reg[0];
        for (int i = 1; i < PIPE_DEPTH; i++)
        begin
            if (ready[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
            else
            begin
                valid_next[i] = valid_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign item_ready = ready[0];

    fvlc_check_stage u_check (
        .clk                 (clk),
        .load                (ready[0]),
        .fat_kind            (fat_kind),
        .bytes_per_sector    (bytes_per_sector),
        .sectors_per_cluster (sectors_per_cluster),
        .reserved_sectors    (reserved_sectors),
        .fat_copies          (fat_copies),
        .root_entries        (root_entries),
        .total_small         (total_small),
        .total_large         (total_large),
        .fat_size_small      (fat_size_small),
        .fat_size_large      (fat_size_large),
        .partition_sectors   (partition_sectors),
        .chk                 (chk)
    );

    fvlc_layout_stage u_layout (
        .clk  (clk),
        .load (ready[1]),
        .chk  (chk),
        .div  (div[0])
    );

    for (genvar g = 0; g < DIV_STAGES; g++)
    begin : g_div
        fvlc_div_stage u_div (
            .clk  (clk),
            .load (ready[g+2]),
            .din  (div[g]),
            .dout (div[g+1])
        );
    end

    assign last = div[DIV_STAGES];

    always_comb
    begin
        if (last.status == ST_OK && last.quot == 32'd0)
        begin
            final_status = ST_NO_CLUSTERS;
        end
        else
        begin
            final_status = last.status;
        end
    end

    assign fail = (final_status != ST_OK);

    logic [3:0]  status_reg;
    logic [31:0] table_start_reg;
    logic [31:0] root_start_reg;
    logic [31:0] data_start_reg;
    logic [31:0] data_clusters_reg;
    logic [16:0] cluster_bytes_reg;
    logic [31:0] total_sectors_reg;
    logic [27:0] link_end_reg;

    // zero every numeric field of a failed record
    always_ff @(posedge clk)
    begin
        if (ready[PIPE_DEPTH-1])
        begin
            status_reg        <= final_status;
            table_start_reg   <= fail ? 32'd0 : {16'd0, last.table_start};
            root_start_reg    <= fail ? 32'd0 : last.root_start;
            data_start_reg    <= fail ? 32'd0 : last.data_start;
            data_clusters_reg <= fail ? 32'd0 : last.quot;
            cluster_bytes_reg <= fail ? 17'd0 : {last.spc, {SECTOR_SHIFT{1'b0}}};
            total_sectors_reg <= fail ? 32'd0 : last.total;
            link_end_reg      <= fail ? 28'd0 : (last.is32 ? FAT32_END : FAT16_END);
        end
    end

    assign result_valid  = valid_reg[PIPE_DEPTH-1];
    assign status        = status_reg;
    assign table_start   = table_start_reg;
    assign root_start    = root_start_reg;
    assign data_start    = data_start_reg;
    assign data_clusters = data_clusters_reg;
    assign cluster_bytes = cluster_bytes_reg;
    assign total_sectors = total_sectors_reg;
    assign link_end      = link_end_reg;

`ifndef SYNTH
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != ST_OK |->
            table_start == 32'd0 && data_clusters == 32'd0 && link_end == 28'd0)
        else $error("failed record carries nonzero fields");

    a_ok_layout: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == ST_OK |->
            data_clusters != 32'd0 && root_start >= table_start &&
            data_start >= root_start && total_sectors >= data_start)
        else $error("accepted layout is out of order");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> status <= ST_NO_CLUSTERS)
        else $error("status code out of range");

    a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("pipeline refuses a beat with the output empty");
`endif

endmodule

// File: rtl/core/fvlc_check_stage.sv
module fvlc_check_stage (
    input  logic             clk,
    input  logic             load,
    input  logic             fat_kind,
    input  logic [15:0]      bytes_per_sector,
    input  logic [7:0]       sectors_per_cluster,
    input  logic [15:0]      reserved_sectors,
    input  logic [7:0]       fat_copies,
    input  logic [15:0]      root_entries,
    input  logic [15:0]      total_small,
    input  logic [31:0]      total_large,
    input  logic [15:0]      fat_size_small,
    input  logic [31:0]      fat_size_large,
    input  logic [31:0]      partition_sectors,
    output fvlc_pkg::chk_t   chk
);
    import fvlc_pkg::*;

    chk_t        chk_reg;
    chk_t        chk_next;
    logic [31:0] total;
    logic [31:0] fsize;
    logic        root_ok;

    always_comb
    begin
        total = (total_large != 32'd0) ? total_large : {16'd0, total_small};
        fsize = fat_kind ? fat_size_large : {16'd0, fat_size_small};
        if (fat_kind)
        begin
            root_ok = (root_entries == 16'd0);
        end
        else
        begin
            root_ok = (root_entries != 16'd0) &&
                      (root_entries[ROOT_ALIGN_BITS-1:0] == '0);
        end

        chk_next.is32         = fat_kind;
        chk_next.total        = total;
        chk_next.fat_area     = 40'(fat_copies) * 40'(fsize);
        chk_next.table_start  = reserved_sectors;
        chk_next.root_sectors = root_entries[15:ENTRY_SHIFT];
        chk_next.spc          = sectors_per_cluster;

        priority if (bytes_per_sector != SECTOR_BYTES)
            chk_next.status = ST_SECTOR_SIZE;
        else if (sectors_per_cluster == 8'd0)
            chk_next.status = ST_ZERO_SPC;
        else if (total > partition_sectors)
            chk_next.status = ST_PARTITION;
        else if (fat_copies == 8'd0)
            chk_next.status = ST_ZERO_FATS;
        else if (fsize == 32'd0)
            chk_next.status = ST_ZERO_FSIZE;
        else if (!root_ok)
            chk_next.status = ST_ROOT_COUNT;
        else
            chk_next.status = ST_OK;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            chk_reg <= chk_next;
        end
    end

    assign chk = chk_reg;

endmodule

// File: rtl/core/fvlc_layout_stage.sv
module fvlc_layout_stage (
    input  logic             clk,
    input  logic             load,
    input  fvlc_pkg::chk_t   chk,
    output fvlc_pkg::div_t   div
);
    import fvlc_pkg::*;

    div_t        div_reg;
    div_t        div_next;
    logic [40:0] root_sum;
    logic [41:0] data_sum;
    logic [41:0] total_w;

    always_comb
    begin
        root_sum = {25'd0, chk.table_start} + {1'b0, chk.fat_area};
        data_sum = {1'b0, root_sum} + (chk.is32 ? 42'd0 : {30'd0, chk.root_sectors});
        total_w  = {10'd0, chk.total};

        div_next.is32        = chk.is32;
        div_next.table_start = chk.table_start;
        div_next.root_start  = root_sum[31:0];
        div_next.data_start  = data_sum[31:0];
        div_next.total       = chk.total;
        div_next.spc         = chk.spc;
        div_next.dividend    = chk.total - data_sum[31:0];
        div_next.partial     = 8'd0;
        div_next.quot        = 32'd0;

        priority if (chk.status != ST_OK)
            div_next.status = chk.status;
        else if (chk.total < {16'd0, chk.table_start})
            div_next.status = ST_BELOW_TABLE;
        else if (!chk.is32 && (total_w < {1'b0, root_sum}))
            div_next.status = ST_BELOW_ROOT;
        else if (total_w < data_sum)
            div_next.status = ST_BELOW_DATA;
        else
            div_next.status = ST_OK;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            div_reg <= div_next;
        end
    end

    assign div = div_reg;

endmodule

// File: rtl/core/fvlc_div_stage.sv
module fvlc_div_stage (
    input  logic             clk,
    input  logic             load,
    input  fvlc_pkg::div_t   din,
    output fvlc_pkg::div_t   dout
);
    import fvlc_pkg::*;

    div_t       dout_reg;
    div_t       dout_next;
    logic [8:0] trial;

    // restoring division, one quotient bit per step
    always_comb
    begin
        dout_next = din;
        trial     = 9'd0;
        for (int k = 0; k < BITS_PER_STEP; k++)
        begin
            trial              = {dout_next.partial, dout_next.dividend[DIV_BITS-1]};
            dout_next.dividend = {dout_next.dividend[DIV_BITS-2:0], 1'b0};
            if (trial >= {1'b0, din.spc})
            begin
                trial          = trial - {1'b0, din.spc};
                dout_next.quot = {dout_next.quot[DIV_BITS-2:0], 1'b1};
            end
            else
            begin
                dout_next.quot = {dout_next.quot[DIV_BITS-2:0], 1'b0};
            end
            dout_next.partial = trial[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule
